// ----- hw/rtl/ppsp_pkg.sv -----
// Shared types and constants for the potentiometer position speed profiler.
`timescale 1ns / 1ps

package ppsp_pkg;

  localparam int CHANNELS_DEF = 4;
  localparam int ADC_BITS_DEF = 12;

  localparam int CH_W       = 2;
  localparam int ANGLE_W    = 13;
  localparam int GOAL_W     = 13;
  localparam int MAXSPD_W   = 15;
  localparam int SPEED_W    = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 15;
  localparam int CNT_W      = 3;

  localparam int GOAL_REGS    = 4;
  localparam int ANGLE_SPAN   = 4640;   // full-scale angle, 290 deg in 1/16 deg
  localparam int FAR_ERR      = 128;
  localparam int NEAR_ERR     = 8;
  localparam int RAMP_GAIN    = 25;
  localparam int RAMP_BASE    = 1500;
  localparam int SETTLE_LIMIT = 5;
  localparam int MAXSPD_RESET = 3000;

  localparam logic OP_SAMPLE  = 1'b0;
  localparam logic OP_RESTART = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_GOAL_CH0  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GOAL_CH1  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GOAL_CH2  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_GOAL_CH3  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_TOP_SPEED = 3'd4;

  // item after angle conversion
  typedef struct packed {
    logic               op;
    logic [CH_W-1:0]    ch;
    logic [ANGLE_W-1:0] angle;
  } item_t;

  // settle counter control from the compute stage
  typedef struct packed {
    logic            fire;
    logic            restart;
    logic [CH_W-1:0] ch;
    logic            zero;
  } settle_req_t;

endpackage

// ----- hw/rtl/ppsp_front.sv -----
// Input register and converter-to-angle stage.
`timescale 1ns / 1ps

module ppsp_front #(
  parameter int ADC_BITS = ppsp_pkg::ADC_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          in_opcode,
  input  logic [ppsp_pkg::CH_W-1:0]     in_channel,
  input  logic [ADC_BITS-1:0]           in_adc_sample,
  input  logic                          s2_ready,
  output logic                          s2_valid,
  output ppsp_pkg::item_t               s2_item
);

  localparam int PROD_W = ADC_BITS + ppsp_pkg::ANGLE_W;

  logic                        s1_valid_r;
  logic                        s1_valid_nxt;
  logic                        s1_op_r;
  logic [ppsp_pkg::CH_W-1:0]   s1_ch_r;
  logic [ADC_BITS-1:0]         s1_adc_r;
  logic                        s2_valid_r;
  logic                        s2_valid_nxt;
  ppsp_pkg::item_t             s2_item_r;
  ppsp_pkg::item_t             s2_item_nxt;
  logic                        s2_free;
  logic                        in_xfer;
  logic                        s1_move;
  logic [PROD_W-1:0]           prod;

  assign s2_free  = !s2_valid_r || s2_ready;
  assign in_stall = s1_valid_r && !s2_free;
  assign in_xfer  = in_valid && !in_stall;
  assign s1_move  = s1_valid_r && s2_free;

  // angle = adc * span / 2^ADC_BITS
  assign prod = PROD_W'(s1_adc_r) * PROD_W'(ppsp_pkg::ANGLE_SPAN);

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_xfer) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_move) begin
      s1_valid_nxt = 1'b0;
    end
    s2_valid_nxt = s2_valid_r;
    if (s2_free) begin
      s2_valid_nxt = s1_valid_r;
    end
    s2_item_nxt.op    = s1_op_r;
    s2_item_nxt.ch    = s1_ch_r;
    s2_item_nxt.angle = prod[ADC_BITS +: ppsp_pkg::ANGLE_W];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
      s2_valid_r <= s2_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_op_r  <= in_opcode;
      s1_ch_r  <= in_channel;
      s1_adc_r <= in_adc_sample;
    end
    if (s1_move) begin
      s2_item_r <= s2_item_nxt;
    end
  end

  assign s2_valid = s2_valid_r;
  assign s2_item  = s2_item_r;

endmodule

// ----- hw/rtl/ppsp_speed.sv -----
// Angle error to signed speed command.
`timescale 1ns / 1ps

module ppsp_speed (
  input  logic [ppsp_pkg::ANGLE_W-1:0]        angle,
  input  logic [ppsp_pkg::GOAL_W-1:0]         goal,
  input  logic [ppsp_pkg::MAXSPD_W-1:0]       top_speed,
  input  logic [ppsp_pkg::CH_W-1:0]           ch,
  output logic signed [ppsp_pkg::SPEED_W-1:0] speed,
  output logic                                zero
);

  logic                              past;
  logic [ppsp_pkg::ANGLE_W-1:0]      err;
  logic [11:0]                       ramp_prod;
  logic [ppsp_pkg::MAXSPD_W-1:0]     mag;
  logic [ppsp_pkg::SPEED_W-1:0]      mag_ext;
  logic                              neg;

  always_comb begin
    past = angle > goal;
    err  = past ? (angle - goal) : (goal - angle);
    // ramp branch only sees err <= 128, so 8 bits of err suffice
    ramp_prod = 12'(err[7:0]) * 12'(ppsp_pkg::RAMP_GAIN);
    if (err > ppsp_pkg::ANGLE_W'(ppsp_pkg::FAR_ERR)) begin
      mag = top_speed;
    end else if (err > ppsp_pkg::ANGLE_W'(ppsp_pkg::NEAR_ERR)) begin
      mag = ppsp_pkg::MAXSPD_W'(ramp_prod[11:1]) +
            ppsp_pkg::MAXSPD_W'(ppsp_pkg::RAMP_BASE);
    end else begin
      mag = '0;
    end
    // channels 1 and 2 drive mirrored motors
    neg     = past ^ ((ch == 2'd1) || (ch == 2'd2));
    mag_ext = {1'b0, mag};
    speed   = neg ? -mag_ext : mag_ext;
    zero    = (mag == '0);
  end

endmodule

// ----- hw/rtl/ppsp_settle.sv -----
// Per-channel settle counters and frozen flag.
`timescale 1ns / 1ps

module ppsp_settle #(
  parameter int CHANNELS = ppsp_pkg::CHANNELS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  ppsp_pkg::settle_req_t req,
  output logic                  frozen
);

  // channel field reaches only the goal-register channels
  localparam int LANES = (CHANNELS < ppsp_pkg::GOAL_REGS) ? CHANNELS : ppsp_pkg::GOAL_REGS;

  logic [ppsp_pkg::CNT_W-1:0] cnt_r   [LANES];
  logic [ppsp_pkg::CNT_W-1:0] cnt_nxt [LANES];

  always_comb begin
    frozen = 1'b0;
    for (int i = 0; i < LANES; i++) begin
      if (req.ch == ppsp_pkg::CH_W'(i) &&
          cnt_r[i] >= ppsp_pkg::CNT_W'(ppsp_pkg::SETTLE_LIMIT)) begin
        frozen = 1'b1;
      end
    end
  end

  always_comb begin
    for (int i = 0; i < LANES; i++) begin
      cnt_nxt[i] = cnt_r[i];
      if (req.fire) begin
        if (req.restart) begin
          cnt_nxt[i] = '0;
        end else if (req.ch == ppsp_pkg::CH_W'(i) &&
                     cnt_r[i] < ppsp_pkg::CNT_W'(ppsp_pkg::SETTLE_LIMIT)) begin
          cnt_nxt[i] = req.zero ? cnt_r[i] + 1'b1 : '0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < LANES; i++) begin
        cnt_r[i] <= '0;
      end
    end else begin
      for (int i = 0; i < LANES; i++) begin
        cnt_r[i] <= cnt_nxt[i];
      end
    end
  end

endmodule

// ----- hw/rtl/potentiometer_position_speed_profile.sv -----
// Potentiometer position speed profiler top level: config, compute stage, output register.
`timescale 1ns / 1ps

// Takes one item per clock with no bubbles while out_stall is low. An input
// transfer loads the input register, then the angle register and then the
// result register, each move waiting for room downstream.
// A sample turns the reading into an angle in 1/16 degree, compares it with
// the channel's goal and returns a signed speed: the full-speed register
// beyond 8 degrees, a ramp of err*12.5+1500 down to half a degree, then 0.
// Sign follows the error and is flipped for channels 1 and 2. After five
// zero commands in a row a channel is frozen and returns 0 with settled set
// until a restart item, which returns nothing. Samples for a channel at or
// above CHANNELS return nothing. The settle counters are read and updated
// in the same stage, so back-to-back samples on one channel see each
// other's effect. Write config only while the block is idle.
module potentiometer_position_speed_profile #(
  parameter int CHANNELS = ppsp_pkg::CHANNELS_DEF,
  parameter int ADC_BITS = ppsp_pkg::ADC_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic                                in_opcode,
  input  logic [ppsp_pkg::CH_W-1:0]           in_channel,
  input  logic [ADC_BITS-1:0]                 in_adc_sample,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [ppsp_pkg::CH_W-1:0]           out_channel,
  output logic signed [ppsp_pkg::SPEED_W-1:0] out_drive_speed,
  output logic                                out_settled,
  input  logic                                cfg_we,
  input  logic [ppsp_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [ppsp_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

  logic [ppsp_pkg::GOAL_W-1:0]         goal_r [ppsp_pkg::GOAL_REGS];
  logic [ppsp_pkg::MAXSPD_W-1:0]       top_speed_r;

  logic                                s2_valid;
  logic                                s2_ready;
  ppsp_pkg::item_t                     s2_item;
  logic                                s2_result;
  logic                                s2_fire;
  logic                                out_free;
  logic                                out_load;

  logic signed [ppsp_pkg::SPEED_W-1:0] speed;
  logic                                speed_zero;
  logic                                frozen;
  ppsp_pkg::settle_req_t               settle_req;

  logic                                out_valid_r;
  logic                                out_valid_nxt;
  logic [ppsp_pkg::CH_W-1:0]           out_channel_r;
  logic signed [ppsp_pkg::SPEED_W-1:0] out_speed_r;
  logic signed [ppsp_pkg::SPEED_W-1:0] out_speed_nxt;
  logic                                out_settled_r;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < ppsp_pkg::GOAL_REGS; i++) begin
        goal_r[i] <= '0;
      end
      top_speed_r <= ppsp_pkg::MAXSPD_W'(ppsp_pkg::MAXSPD_RESET);
    end else if (cfg_we) begin
      case (cfg_index)
        ppsp_pkg::REG_GOAL_CH0:  goal_r[0]   <= cfg_wdata[ppsp_pkg::GOAL_W-1:0];
        ppsp_pkg::REG_GOAL_CH1:  goal_r[1]   <= cfg_wdata[ppsp_pkg::GOAL_W-1:0];
        ppsp_pkg::REG_GOAL_CH2:  goal_r[2]   <= cfg_wdata[ppsp_pkg::GOAL_W-1:0];
        ppsp_pkg::REG_GOAL_CH3:  goal_r[3]   <= cfg_wdata[ppsp_pkg::GOAL_W-1:0];
        ppsp_pkg::REG_TOP_SPEED: top_speed_r <= cfg_wdata[ppsp_pkg::MAXSPD_W-1:0];
        default: begin
        end
      endcase
    end
  end

  ppsp_front #(
    .ADC_BITS (ADC_BITS)
  ) u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_opcode     (in_opcode),
    .in_channel    (in_channel),
    .in_adc_sample (in_adc_sample),
    .s2_ready      (s2_ready),
    .s2_valid      (s2_valid),
    .s2_item       (s2_item)
  );

  ppsp_speed u_speed (
    .angle     (s2_item.angle),
    .goal      (goal_r[s2_item.ch]),
    .top_speed (top_speed_r),
    .ch        (s2_item.ch),
    .speed     (speed),
    .zero      (speed_zero)
  );

  // restarts and out-of-range channels retire without a result
  assign s2_result = (s2_item.op == ppsp_pkg::OP_SAMPLE) && (32'(s2_item.ch) < CHANNELS);
  assign out_free  = !out_valid_r || !out_stall;
  assign s2_fire   = s2_valid && (!s2_result || out_free);
  assign s2_ready  = !s2_valid || s2_fire;
  assign out_load  = s2_fire && s2_result;

  always_comb begin
    settle_req.fire    = s2_fire;
    settle_req.restart = (s2_item.op == ppsp_pkg::OP_RESTART);
    settle_req.ch      = s2_item.ch;
    settle_req.zero    = speed_zero;
  end

  ppsp_settle #(
    .CHANNELS (CHANNELS)
  ) u_settle (
    .clk    (clk),
    .rst_n  (rst_n),
    .req    (settle_req),
    .frozen (frozen)
  );

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
    out_speed_nxt = frozen ? '0 : speed;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_channel_r <= s2_item.ch;
      out_speed_r   <= out_speed_nxt;
      out_settled_r <= frozen;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_channel     = out_channel_r;
  assign out_drive_speed = out_speed_r;
  assign out_settled     = out_settled_r;

`ifndef NO_ASSERTIONS
  // a frozen channel always commands zero
  a_settled_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_settled |-> out_drive_speed == '0)
    else $error("settled result with nonzero speed");

  // a pending result never gets overwritten while the output is stalled
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_stall && s2_valid && s2_result |-> !s2_fire)
    else $error("result register overwritten under stall");

  // nothing comes out in the cycle after reset
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid right after reset");
`endif

endmodule
